FILE: hw/rtl/lcsh_pkg.sv
// Package for the layer charge-sum histogrammer.
// Holds the word types, operation and register codes and fixed constants.
// Depends on nothing; every other file of the block but lcsh_ram refers to it.
package lcsh_pkg;

    localparam logic [1:0] OP_CLUSTER = 2'd0;
    localparam logic [1:0] OP_FLUSH   = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam int          APB_AW          = 4;
    localparam logic [1:0]  REG_PULSE_THRESHOLD = 2'd0;
    localparam logic [1:0]  REG_MIN_WIDTH   = 2'd1;
    localparam logic [1:0]  REG_MAX_WIDTH   = 2'd2;

    localparam logic [9:0]  RST_PULSE_THRESHOLD = 10'd10;
    localparam logic [7:0]  RST_MIN_WIDTH   = 8'd7;
    localparam logic [7:0]  RST_MAX_WIDTH   = 8'd50;

    localparam logic [3:0]  MODULE_A        = 4'd1;
    localparam logic [3:0]  MODULE_B        = 4'd3;
    localparam logic [3:0]  MODULE_C        = 4'd6;
    localparam logic [6:0]  OFFSET_B        = 7'd28;
    localparam logic [6:0]  OFFSET_C        = 7'd56;

    localparam logic [23:0] SUM_MAX         = 24'hFFFFFF;
    localparam logic [31:0] COUNT_MAX       = 32'hFFFFFFFF;
    localparam logic [23:0] RANGE_HI        = 24'd20000;
    localparam longint      RANGE_SPAN      = 64'd19999;
    localparam int          SPAN_W          = 15;

    localparam int          RESQ_DEPTH      = 8;
    localparam int          RESQ_AW         = 3;
    localparam int          CREDIT_W        = 4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [9:0]  pulse_max;
        logic [7:0]  cluster_length;
        logic [3:0]  module_id;
        logic [5:0]  module_layer;
        logic [15:0] charge;
        logic [6:0]  read_layer;
        logic [9:0]  read_bin;
    } item_t;

    typedef struct packed {
        logic        run_closed;
        logic        run_filled;
        logic [6:0]  closed_layer;
        logic [23:0] closed_sum;
        logic [31:0] bin_count;
    } result_t;

    typedef struct packed {
        logic    valid;
        logic    fill;
        logic    rd;
        result_t res;
    } ctl_t;

    typedef struct packed {
        ctl_t       ctl;
        logic [6:0] read_layer;
        logic [9:0] read_bin;
    } front_t;

endpackage

FILE: hw/rtl/lcsh_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module lcsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/lcsh_front.sv
// Front end: configuration registers, cluster selection and run tracking.
// Depends on lcsh_pkg.
module lcsh_front #(
    parameter int NUM_LAYERS = 85,
    parameter int NUM_BINS   = 1000
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lcsh_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    input  logic                       accept,
    input  lcsh_pkg::item_t            item,
    output lcsh_pkg::front_t           front
);

    localparam int TOTAL_BINS = NUM_BINS + 2;

    logic [9:0]  thr_reg, thr_next;
    logic [7:0]  minw_reg, minw_next;
    logic [7:0]  maxw_reg, maxw_next;
    logic [23:0] run_sum_reg, run_sum_next;
    logic        run_active_reg, run_active_next;
    logic [6:0]  run_layer_reg, run_layer_next;
    lcsh_pkg::front_t front_reg, front_next;

    logic        cfg_wr;
    logic        mod_ok;
    logic [6:0]  layer;
    logic        keep;
    logic        close;
    logic        in_range;
    logic        read_ok;
    logic [23:0] base_sum;
    logic [24:0] sum_wide;

    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        thr_next  = thr_reg;
        minw_next = minw_reg;
        maxw_next = maxw_reg;
        prdata    = 32'd0;
        unique case (paddr[3:2])
            lcsh_pkg::REG_PULSE_THRESHOLD:
            begin
                prdata = 32'(thr_reg);
                if (cfg_wr)
                begin
                    thr_next = pwdata[9:0];
                end
            end
            lcsh_pkg::REG_MIN_WIDTH:
            begin
                prdata = 32'(minw_reg);
                if (cfg_wr)
                begin
                    minw_next = pwdata[7:0];
                end
            end
            lcsh_pkg::REG_MAX_WIDTH:
            begin
                prdata = 32'(maxw_reg);
                if (cfg_wr)
                begin
                    maxw_next = pwdata[7:0];
                end
            end
            default:
            begin
                prdata = 32'd0;
            end
        endcase
    end

    always_comb
    begin
        mod_ok = 1'b1;
        layer  = {1'b0, item.module_layer};
        priority if (item.module_id == lcsh_pkg::MODULE_A)
        begin
            layer = {1'b0, item.module_layer};
        end
        else if (item.module_id == lcsh_pkg::MODULE_B)
        begin
            layer = {1'b0, item.module_layer} + lcsh_pkg::OFFSET_B;
        end
        else if (item.module_id == lcsh_pkg::MODULE_C)
        begin
            layer = {1'b0, item.module_layer} + lcsh_pkg::OFFSET_C;
        end
        else
        begin
            mod_ok = 1'b0;
        end

        keep = (item.operation == lcsh_pkg::OP_CLUSTER) && mod_ok
            && (item.pulse_max >= thr_reg)
            && (item.cluster_length >= minw_reg)
            && (item.cluster_length <= maxw_reg);

        close = (keep && run_active_reg && (layer != run_layer_reg))
            || ((item.operation == lcsh_pkg::OP_FLUSH) && run_active_reg);

        in_range = 32'(run_layer_reg) < 32'(NUM_LAYERS);
        read_ok  = (32'(item.read_layer) < 32'(NUM_LAYERS))
            && (32'(item.read_bin) < 32'(TOTAL_BINS));

        base_sum = close ? 24'd0 : run_sum_reg;
        sum_wide = {1'b0, base_sum} + 25'(item.charge);

        run_sum_next    = run_sum_reg;
        run_active_next = run_active_reg;
        run_layer_next  = run_layer_reg;
        if (accept && keep)
        begin
            run_sum_next    = sum_wide[24] ? lcsh_pkg::SUM_MAX : sum_wide[23:0];
            run_layer_next  = layer;
            run_active_next = 1'b1;
        end
        else if (accept && (item.operation == lcsh_pkg::OP_FLUSH))
        begin
            run_sum_next    = 24'd0;
            run_active_next = 1'b0;
        end

        front_next                       = '0;
        front_next.ctl.valid             = accept;
        front_next.ctl.fill              = accept && close && in_range;
        front_next.ctl.rd                = accept && (item.operation == lcsh_pkg::OP_READ)
                                           && read_ok;
        front_next.ctl.res.run_closed    = close;
        front_next.ctl.res.run_filled    = close && in_range;
        front_next.ctl.res.closed_layer  = close ? run_layer_reg : 7'd0;
        front_next.ctl.res.closed_sum    = close ? run_sum_reg : 24'd0;
        front_next.ctl.res.bin_count     = 32'd0;
        front_next.read_layer            = item.read_layer;
        front_next.read_bin              = item.read_bin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg        <= lcsh_pkg::RST_PULSE_THRESHOLD;
            minw_reg       <= lcsh_pkg::RST_MIN_WIDTH;
            maxw_reg       <= lcsh_pkg::RST_MAX_WIDTH;
            run_sum_reg    <= 24'd0;
            run_active_reg <= 1'b0;
            run_layer_reg  <= 7'd0;
            front_reg      <= '0;
        end
        else
        begin
            thr_reg        <= thr_next;
            minw_reg       <= minw_next;
            maxw_reg       <= maxw_next;
            run_sum_reg    <= run_sum_next;
            run_active_reg <= run_active_next;
            run_layer_reg  <= run_layer_next;
            front_reg      <= front_next;
        end
    end

    assign front = front_reg;

endmodule

FILE: hw/rtl/lcsh_addr.sv
// Bin and address pipeline: turns a closed run sum into a histogram address.
// Depends on lcsh_pkg.
module lcsh_addr #(
    parameter int NUM_LAYERS = 85,
    parameter int NUM_BINS   = 1000
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  lcsh_pkg::front_t                             front,
    output lcsh_pkg::ctl_t                               ctl,
    output logic [$clog2(NUM_LAYERS*(NUM_BINS+2))-1:0]   addr
);

    localparam int TOTAL_BINS = NUM_BINS + 2;
    localparam int AW   = $clog2(NUM_LAYERS * TOTAL_BINS);
    localparam int BW   = $clog2(TOTAL_BINS);
    localparam int NBW  = $clog2(NUM_BINS + 1);
    localparam int XW   = lcsh_pkg::SPAN_W + NBW;
    localparam int MW   = XW + 1;
    localparam int SH   = XW + lcsh_pkg::SPAN_W;
    localparam int PW   = XW + MW;
    localparam logic [63:0] RECIP64 = (64'd1 << SH) / lcsh_pkg::RANGE_SPAN + 64'd1;
    localparam logic [MW-1:0] RECIP = MW'(RECIP64);

    // Stage one: scaled sum and row base.
    lcsh_pkg::ctl_t  c1_reg;
    logic            under1_reg, over1_reg;
    logic [XW-1:0]   x1_reg;
    logic [AW-1:0]   base1_reg;
    logic [BW-1:0]   rbin1_reg;

    // Stage two: quotient.
    lcsh_pkg::ctl_t  c2_reg;
    logic            under2_reg, over2_reg;
    logic [BW-1:0]   q2_reg;
    logic [AW-1:0]   base2_reg;
    logic [BW-1:0]   rbin2_reg;

    // Stage three: address.
    lcsh_pkg::ctl_t  c3_reg;
    logic [AW-1:0]   addr3_reg;

    logic [lcsh_pkg::SPAN_W-1:0] sm1;
    logic [6:0]      lay;
    logic [XW-1:0]   x1_next;
    logic [AW-1:0]   base1_next;
    logic [PW-1:0]   prod;
    logic [BW-1:0]   bin;

    always_comb
    begin
        sm1        = lcsh_pkg::SPAN_W'(front.ctl.res.closed_sum - 24'd1);
        x1_next    = XW'(sm1) * XW'(NUM_BINS);
        lay        = front.ctl.fill ? front.ctl.res.closed_layer : front.read_layer;
        base1_next = AW'(32'(lay) * 32'(TOTAL_BINS));
        prod       = PW'(x1_reg) * PW'(RECIP);
        if (!c2_reg.fill)
        begin
            bin = rbin2_reg;
        end
        else if (under2_reg)
        begin
            bin = '0;
        end
        else if (over2_reg)
        begin
            bin = BW'(NUM_BINS + 1);
        end
        else
        begin
            bin = q2_reg + BW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end
        else
        begin
            c1_reg <= front.ctl;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        under1_reg <= (front.ctl.res.closed_sum == 24'd0);
        over1_reg  <= (front.ctl.res.closed_sum >= lcsh_pkg::RANGE_HI);
        x1_reg     <= x1_next;
        base1_reg  <= base1_next;
        rbin1_reg  <= BW'(front.read_bin);

        under2_reg <= under1_reg;
        over2_reg  <= over1_reg;
        q2_reg     <= BW'(prod >> SH);
        base2_reg  <= base1_reg;
        rbin2_reg  <= rbin1_reg;

        addr3_reg  <= base2_reg + AW'(bin);
    end

    assign ctl  = c3_reg;
    assign addr = addr3_reg;

endmodule

FILE: hw/rtl/lcsh_update.sv
// Histogram store: clearing pass, read-modify-write with forwarding, bin reads.
// Depends on lcsh_pkg and lcsh_ram.
module lcsh_update #(
    parameter int DEPTH = 85170
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  lcsh_pkg::ctl_t           ctl,
    input  logic [$clog2(DEPTH)-1:0] addr,
    output logic                     busy,
    output logic                     res_valid,
    output lcsh_pkg::result_t        res
);

    localparam int AW = $clog2(DEPTH);

    logic           clr_busy_reg, clr_busy_next;
    logic [AW-1:0]  clr_addr_reg, clr_addr_next;
    lcsh_pkg::ctl_t c4_reg;
    logic [AW-1:0]  a4_reg;
    logic           fwd_valid_reg;
    logic [AW-1:0]  fwd_addr_reg;
    logic [31:0]    fwd_data_reg;

    logic           re;
    logic [31:0]    rdata;
    logic [31:0]    cur;
    logic [31:0]    inc;
    logic           fill_we;
    logic           we;
    logic [AW-1:0]  waddr;
    logic [31:0]    wdata;

    assign re = ctl.valid && (ctl.fill || ctl.rd);

    lcsh_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (addr),
        .rdata (rdata)
    );

    always_comb
    begin
        cur = (fwd_valid_reg && (fwd_addr_reg == a4_reg)) ? fwd_data_reg : rdata;
        inc = (cur == lcsh_pkg::COUNT_MAX) ? cur : cur + 32'd1;
        fill_we = c4_reg.valid && c4_reg.fill;

        we    = clr_busy_reg || fill_we;
        waddr = clr_busy_reg ? clr_addr_reg : a4_reg;
        wdata = clr_busy_reg ? 32'd0 : inc;

        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end

        res           = c4_reg.res;
        res.bin_count = c4_reg.rd ? cur : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            c4_reg        <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            c4_reg        <= ctl;
            fwd_valid_reg <= fill_we && !clr_busy_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a4_reg       <= addr;
        fwd_addr_reg <= a4_reg;
        fwd_data_reg <= inc;
    end

    assign busy      = clr_busy_reg;
    assign res_valid = c4_reg.valid;

endmodule

FILE: hw/rtl/lcsh_resq.sv
// Result queue that decouples the pipeline from the output handshake.
// Depends on lcsh_pkg.
module lcsh_resq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lcsh_pkg::result_t push_data,
    input  logic              pop,
    output logic              not_empty,
    output lcsh_pkg::result_t head
);

    lcsh_pkg::result_t            slot_reg [lcsh_pkg::RESQ_DEPTH];
    logic [lcsh_pkg::RESQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [lcsh_pkg::RESQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [lcsh_pkg::RESQ_AW:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + lcsh_pkg::RESQ_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + lcsh_pkg::RESQ_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (lcsh_pkg::RESQ_AW + 1)'(push)
                      - (lcsh_pkg::RESQ_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

endmodule

FILE: hw/rtl/layer_charge_sum_histogrammer_core.sv
// Top level of the layer charge-sum histogrammer.
// Depends on lcsh_pkg, lcsh_front, lcsh_addr, lcsh_update and lcsh_resq.
//
//   Channel   Handshake                        Word
//   item      item_valid / item_ready          lcsh_pkg::item_t
//   result    result_valid / result_ready      lcsh_pkg::result_t
//   config    psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// One word is accepted per cycle while item_ready is high; results leave in order.
// The histogram memory takes one read and one write per cycle; back-to-back hits
// on one bin are forwarded from the previous write.
// After reset a clearing pass writes zero to all NUM_LAYERS*(NUM_BINS+2) entries,
// one per cycle, and item_ready stays low until it ends.
// Up to eight words may be in flight or waiting; a stalled output fills them.
module layer_charge_sum_histogrammer_core #(
    parameter int NUM_LAYERS = 85,
    parameter int NUM_BINS   = 1000
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lcsh_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  lcsh_pkg::item_t             item,
    output logic                        result_valid,
    input  logic                        result_ready,
    output lcsh_pkg::result_t           result
);

    localparam int DEPTH = NUM_LAYERS * (NUM_BINS + 2);
    localparam int AW    = $clog2(DEPTH);

    logic                          accept;
    logic                          deliver;
    logic                          busy;
    logic [lcsh_pkg::CREDIT_W-1:0] credit_reg, credit_next;
    lcsh_pkg::front_t              front;
    lcsh_pkg::ctl_t                ctl;
    logic [AW-1:0]                 addr;
    logic                          res_valid;
    lcsh_pkg::result_t             res;

    assign pready     = 1'b1;
    assign item_ready = !busy && (credit_reg < lcsh_pkg::CREDIT_W'(lcsh_pkg::RESQ_DEPTH));
    assign accept     = item_valid && item_ready;
    assign deliver    = result_valid && result_ready;

    always_comb
    begin
        credit_next = credit_reg + lcsh_pkg::CREDIT_W'(accept)
                      - lcsh_pkg::CREDIT_W'(deliver);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    lcsh_front #(
        .NUM_LAYERS(NUM_LAYERS),
        .NUM_BINS  (NUM_BINS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .accept  (accept),
        .item    (item),
        .front   (front)
    );

    lcsh_addr #(
        .NUM_LAYERS(NUM_LAYERS),
        .NUM_BINS  (NUM_BINS)
    ) u_addr (
        .clk   (clk),
        .rst_n (rst_n),
        .front (front),
        .ctl   (ctl),
        .addr  (addr)
    );

    lcsh_update #(
        .DEPTH(DEPTH)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .addr      (addr),
        .busy      (busy),
        .res_valid (res_valid),
        .res       (res)
    );

    lcsh_resq u_resq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (deliver),
        .not_empty (result_valid),
        .head      (result)
    );

endmodule
